>>> hw/rtl/apts_pkg.sv
// shared types and constants for the aging priority scheduler
`timescale 1ns / 1ps
package apts_pkg;
    localparam logic [1:0] MODE_SETUP   = 2'd0;
    localparam logic [1:0] MODE_ENABLE  = 2'd1;
    localparam logic [1:0] MODE_DISABLE = 2'd2;
    localparam logic [1:0] MODE_TICK    = 2'd3;
    localparam int PRIO_W = 8;
    localparam int TIME_W = 32;
    localparam int AGED_W = 16;
    localparam logic [AGED_W-1:0] AGED_MAX = '1;

    // one task table row
    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [TIME_W-1:0] period;
        logic              evt;
        logic [TIME_W-1:0] last_run;
        logic [AGED_W-1:0] aged;
    } t_task;

    // divider handshake
    typedef struct packed {
        logic              start;
        logic [TIME_W-1:0] num;
        logic [TIME_W-1:0] den;
    } t_div_req;
endpackage

>>> hw/rtl/aging_priority_task_scheduler_core.sv
// top level: task table and run queue memories, tick sequencer
`timescale 1ns / 1ps
// setup: the row is read, then written; enable/disable: each queue entry searched is read then
// checked, and on removal each later entry is read then shifted down; tick: a realtime scan reads
// each queue entry then its task row, then each task is updated, through the divider if it divides
// o_done strobes in the first cycle with busy low; a start held then transfers at its end earliest
// synchronous active-low reset clears control state; task table rows carry valid bits
// and read as their reset values until written; results cannot be stalled
module aging_priority_task_scheduler_core
    import apts_pkg::*;
#(
    parameter int TASK_SLOTS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_wdata,
    input  logic [1:0]        i_mode,
    input  logic [3:0]        i_task_id,
    input  logic [7:0]        i_static_priority,
    input  logic [31:0]       i_period_us,
    input  logic              i_event_driven,
    input  logic [31:0]       i_now_us,
    input  logic [15:0]       i_signal_mask,
    output logic              o_done,
    output logic              o_accepted,
    output logic              o_task_valid,
    output logic [3:0]        o_selected_task,
    output logic [4:0]        o_waiting_count
);
    localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int LW = $clog2(TASK_SLOTS + 1);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_SETUP  = 5'd1;
    localparam logic [4:0] S_SETW   = 5'd2;
    localparam logic [4:0] S_QRD    = 5'd3;
    localparam logic [4:0] S_QCHK   = 5'd4;
    localparam logic [4:0] S_SHRD   = 5'd5;
    localparam logic [4:0] S_SHWR   = 5'd6;
    localparam logic [4:0] S_RTRD   = 5'd7;
    localparam logic [4:0] S_RTQ    = 5'd8;
    localparam logic [4:0] S_RTCHK  = 5'd9;
    localparam logic [4:0] S_MQRD   = 5'd10;
    localparam logic [4:0] S_MQ     = 5'd11;
    localparam logic [4:0] S_MDIV   = 5'd12;
    localparam logic [4:0] S_MWAIT  = 5'd13;
    localparam logic [4:0] S_MUPD   = 5'd14;
    localparam logic [4:0] S_FIN    = 5'd15;
    localparam logic [4:0] S_RESULT = 5'd16;

    // memories
    logic [IW-1:0] m_queue [TASK_SLOTS];
    t_task         m_task  [TASK_SLOTS];
    logic [TASK_SLOTS-1:0] r_tvalid;

    logic [4:0]    r_state;
    logic [7:0]    r_rt_level;
    logic [LW-1:0] r_qlen;
    logic [LW-1:0] r_idx;
    logic [1:0]    r_mode;
    logic [3:0]    r_id;
    logic [7:0]    r_sprio;
    logic [31:0]   r_period, r_now;
    logic          r_evt;
    logic [15:0]   r_mask;
    logic          r_acc, r_found, r_rt_pend;
    logic [AGED_W-1:0] r_best;
    logic [IW-1:0] r_best_id;
    logic [4:0]    r_wait;
    logic [31:0]   r_dist;
    logic          r_rt_stop;
    logic [IW-1:0] r_qdata;
    t_task         r_trd;
    logic          r_trd_valid;
    logic [IW-1:0] r_cur;
    logic [31:0]   r_age;
    logic [39:0]   r_prod;
    logic          r_out_done;

    // queue port
    logic          q_we;
    logic [IW-1:0] q_waddr, q_wdata, q_raddr;
    // task port
    logic          t_we;
    logic [IW-1:0] t_waddr, t_raddr;
    t_task         t_wdata;

    t_div_req    w_div;
    logic        w_div_done;
    logic [31:0] w_quot;
    t_task       w_row;

    logic        w_is_rt;
    logic [31:0] w_next, w_diffn;
    logic        w_evt_sig;
    logic [IW-1:0] w_idx;
    logic        w_id_ok, w_qend, w_append;
    logic [40:0] w_sat_in;
    logic [AGED_W-1:0] w_sat;
    logic        w_upd, w_take;
    logic [AGED_W-1:0] w_na;

    apts_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_div),
        .o_done (w_div_done),
        .o_quot (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (q_we) m_queue[q_waddr] <= q_wdata;
        r_qdata <= m_queue[q_raddr];
        if (t_we) m_task[t_waddr] <= t_wdata;
        r_trd       <= m_task[t_raddr];
        r_trd_valid <= r_tvalid[t_raddr];
    end

    // row as seen through valid bit
    always_comb begin
        if (r_trd_valid) w_row = r_trd;
        else begin
            w_row = '0;
            w_row.period = 32'd1;
        end
    end

    assign w_is_rt   = w_row.prio >= r_rt_level;
    assign w_next    = w_row.last_run + w_row.period;
    assign w_diffn   = r_now - w_next;
    // ids of 16 and up have no signal bit
    assign w_evt_sig = (32'(r_cur) < 32'd16) ? r_mask[4'(r_cur)] : 1'b0;

    assign w_idx    = r_idx[IW-1:0];
    assign w_id_ok  = (32'(r_id) < 32'(TASK_SLOTS));
    assign w_qend   = (r_idx >= r_qlen) || !w_id_ok;
    assign w_append = (r_state == S_QRD) && w_qend && (r_mode == MODE_ENABLE) && w_id_ok
                      && (r_qlen < LW'(TASK_SLOTS));

    assign w_sat_in = {1'b0, r_prod} + 41'd1;
    assign w_sat    = (w_sat_in > 41'(AGED_MAX)) ? AGED_MAX : w_sat_in[AGED_W-1:0];

    // aged priority update and selection for the task under r_cur
    always_comb begin
        if (w_row.evt) w_upd = (w_row.aged != '0) || w_evt_sig;
        else w_upd = (r_age != '0);
        w_na   = w_upd ? w_sat : w_row.aged;
        w_take = (w_na > r_best) && (!r_rt_pend || w_is_rt || r_age > 32'd1);
    end

    always_comb begin
        q_we = 1'b0; q_waddr = w_idx; q_wdata = r_qdata; q_raddr = w_idx;
        t_we = 1'b0; t_waddr = r_cur; t_wdata = w_row; t_raddr = r_cur;
        w_div = '0;
        w_div.num = r_now - w_row.last_run;
        w_div.den = w_row.period;
        unique case (r_state)
            S_SETUP: t_raddr = IW'(r_id);
            S_SETW: begin
                t_we = w_id_ok;
                t_waddr = IW'(r_id);
                t_wdata.prio = r_sprio;
                t_wdata.period = r_period;
                t_wdata.evt = r_evt;
            end
            S_QRD: begin
                if (w_append) begin
                    q_we = 1'b1;
                    q_waddr = IW'(r_qlen);
                    q_wdata = IW'(r_id);
                end
            end
            S_SHRD: q_raddr = IW'(r_idx + LW'(1));
            S_SHWR: q_we = 1'b1;
            S_RTQ: t_raddr = r_qdata;
            S_MQRD: begin
                if (r_idx >= r_qlen) t_raddr = r_best_id;
            end
            S_MQ: t_raddr = r_qdata;
            S_MDIV: w_div.start = w_row.evt ? (w_row.aged != '0) : 1'b1;
            S_MUPD: begin
                t_we = w_upd;
                t_wdata.aged = w_na;
            end
            S_FIN: begin
                t_we = r_found;
                t_waddr = r_best_id;
                t_wdata.last_run = r_now;
                t_wdata.aged = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_rt_level <= 8'd6;
            r_qlen     <= '0;
            r_tvalid   <= '0;
            r_out_done <= 1'b0;
            r_acc      <= 1'b0;
            r_found    <= 1'b0;
            r_best_id  <= '0;
            r_wait     <= '0;
        end else begin
            r_out_done <= 1'b0;
            if (i_cfg_we) r_rt_level <= i_cfg_wdata;
            if (t_we) r_tvalid[t_waddr] <= 1'b1;
            unique case (r_state)
                S_IDLE: if (start) begin
                    r_mode <= i_mode; r_id <= i_task_id; r_sprio <= i_static_priority;
                    r_period <= i_period_us; r_evt <= i_event_driven;
                    r_now <= i_now_us; r_mask <= i_signal_mask;
                    r_idx <= '0; r_acc <= 1'b0; r_found <= 1'b0; r_best <= '0;
                    r_best_id <= '0; r_wait <= '0; r_dist <= '0; r_rt_stop <= 1'b0;
                    unique case (i_mode)
                        MODE_SETUP:   r_state <= S_SETUP;
                        MODE_ENABLE:  r_state <= S_QRD;
                        MODE_DISABLE: r_state <= S_QRD;
                        MODE_TICK:    r_state <= S_RTRD;
                    endcase
                end
                S_SETUP: r_state <= S_SETW;
                S_SETW: begin
                    r_acc <= 1'b1;
                    r_state <= S_RESULT;
                end
                S_QRD: begin
                    if (w_qend) begin
                        if (w_append) begin
                            r_qlen <= r_qlen + LW'(1);
                            r_acc <= 1'b1;
                        end
                        r_state <= S_RESULT;
                    end else r_state <= S_QCHK;
                end
                S_QCHK: begin
                    if (r_qdata == IW'(r_id)) begin
                        if (r_mode == MODE_DISABLE) begin
                            r_acc <= 1'b1;
                            r_state <= S_SHRD;
                        end else r_state <= S_RESULT;
                    end else begin
                        r_idx <= r_idx + LW'(1);
                        r_state <= S_QRD;
                    end
                end
                S_SHRD: begin
                    if (r_idx + LW'(1) >= r_qlen) begin
                        r_qlen <= r_qlen - LW'(1);
                        r_state <= S_RESULT;
                    end else r_state <= S_SHWR;
                end
                S_SHWR: begin
                    r_idx <= r_idx + LW'(1);
                    r_state <= S_SHRD;
                end
                // realtime scan: queue entry, then its task row
                S_RTRD: begin
                    if (r_idx >= r_qlen || r_rt_stop) begin
                        r_rt_pend <= (r_dist == '0);
                        r_idx <= '0;
                        r_state <= S_MQRD;
                    end else r_state <= S_RTQ;
                end
                S_RTQ: r_state <= S_RTCHK;
                S_RTCHK: begin
                    if (!w_is_rt) r_rt_stop <= 1'b1;
                    else begin
                        r_dist <= w_diffn[31] ? (w_next - r_now) : '0;
                        r_idx <= r_idx + LW'(1);
                    end
                    r_state <= S_RTRD;
                end
                S_MQRD: begin
                    if (r_idx >= r_qlen) r_state <= S_FIN;
                    else r_state <= S_MQ;
                end
                S_MQ: begin
                    r_cur <= r_qdata;
                    r_state <= S_MDIV;
                end
                S_MDIV: begin
                    if (w_div.start) r_state <= S_MWAIT;
                    else begin
                        r_age <= {31'd0, w_evt_sig};
                        r_prod <= {32'd0, w_row.prio};
                        r_state <= S_MUPD;
                    end
                end
                S_MWAIT: if (w_div_done) begin
                    r_age  <= w_quot;
                    r_prod <= 40'(w_row.prio) * 40'(w_quot);
                    r_state <= S_MUPD;
                end
                S_MUPD: begin
                    if (w_upd) r_wait <= (r_wait == 5'd31) ? r_wait : r_wait + 5'd1;
                    if (w_take) begin
                        r_best <= w_na; r_best_id <= r_cur; r_found <= 1'b1;
                    end
                    r_idx <= r_idx + LW'(1);
                    r_state <= S_MQRD;
                end
                // selected row is stamped with the tick time here
                S_FIN: begin
                    r_acc <= 1'b1;
                    r_state <= S_RESULT;
                end
                S_RESULT: begin
                    r_out_done <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy            = (r_state != S_IDLE);
    assign o_done          = r_out_done;
    assign o_accepted      = r_acc;
    assign o_task_valid    = r_found;
    assign o_selected_task = 4'(r_best_id);
    assign o_waiting_count = r_wait;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy);
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done);
    a_valid_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_task_valid) |-> o_accepted);
    a_reject_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_accepted) |-> (!o_task_valid && o_waiting_count == '0));
    a_qlen_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qlen <= LW'(TASK_SLOTS));
endmodule

>>> hw/rtl/apts_divider.sv
// radix-2 restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module apts_divider
    import apts_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_div_req          i_req,
    output logic              o_done,
    output logic [TIME_W-1:0] o_quot
);
    logic [TIME_W-1:0] r_quot, r_den;
    logic [TIME_W:0]   r_rem;
    logic [5:0]        r_cnt;
    logic              r_busy, r_done;
    logic [TIME_W:0]   w_sh;
    logic [TIME_W:0]   w_diff;

    assign w_sh   = {r_rem[TIME_W-1:0], r_quot[TIME_W-1]};
    assign w_diff = w_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
                r_rem  <= '0;
                r_quot <= i_req.num;
                r_den  <= (i_req.den == '0) ? TIME_W'(1) : i_req.den;
            end else if (r_busy) begin
                if (!w_diff[TIME_W]) begin
                    r_rem  <= w_diff;
                    r_quot <= {r_quot[TIME_W-2:0], 1'b1};
                end else begin
                    r_rem  <= w_sh;
                    r_quot <= {r_quot[TIME_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(TIME_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

>>> dv/aging_priority_task_scheduler_core_tb.sv
// self-checking testbench for the aging priority task scheduler core
`timescale 1ns / 1ps
module aging_priority_task_scheduler_core_tb
    import apts_pkg::*;
;

    localparam int SLOTS = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic       accepted;
        logic       task_valid;
        logic [3:0] selected_task;
        logic [4:0] waiting_count;
    } t_sched_result;

    class sched_scoreboard;
        logic [7:0]  rt_level;
        logic [3:0]  run_queue [SLOTS];
        int          run_len;
        logic [7:0]  prio [SLOTS];
        logic [31:0] period [SLOTS];
        logic        evt [SLOTS];
        logic [31:0] last_run [SLOTS];
        logic [15:0] aged [SLOTS];
        t_sched_result pending [$];
        int          mismatches;
        int          checked;
        int          ticks_selected;

        function new();
            rt_level = 8'd6;
            run_len = 0;
            mismatches = 0;
            checked = 0;
            ticks_selected = 0;
            for (int i = 0; i < SLOTS; i++) begin
                prio[i] = 0; period[i] = 1; evt[i] = 0; last_run[i] = 0; aged[i] = 0;
                run_queue[i] = 0;
            end
        endfunction

        function logic [15:0] aged_value(logic [7:0] p, logic [31:0] age);
            longint unsigned v;
            v = 64'd1 + longint'(p) * longint'(age);
            return (v > 65535) ? 16'hFFFF : v[15:0];
        endfunction

        function logic [31:0] age_of(int t, logic [31:0] now);
            logic [31:0] p;
            p = (period[t] == 0) ? 32'd1 : period[t];
            return (now - last_run[t]) / p;
        endfunction

        function bit is_queued(logic [3:0] id);
            for (int i = 0; i < run_len; i++)
                if (run_queue[i] == id) return 1;
            return 0;
        endfunction

        // compute expected result of one accepted command
        function void note_command(logic [1:0] mode, logic [3:0] id, logic [7:0] sp,
                                   logic [31:0] per, logic ev, logic [31:0] now,
                                   logic [15:0] mask);
            t_sched_result r;
            logic [31:0] rt_dist, nxt, age;
            logic [15:0] best;
            bit found, rt_free, sig;
            int best_id, waiting, t;
            r = '0;
            r.accepted = 1'b1;
            case (mode)
                MODE_SETUP: begin
                    prio[id] = sp; period[id] = per; evt[id] = ev;
                end
                MODE_ENABLE: begin
                    r.accepted = 1'b0;
                    if (!is_queued(id) && run_len < SLOTS) begin
                        run_queue[run_len] = id;
                        run_len++;
                        r.accepted = 1'b1;
                    end
                end
                MODE_DISABLE: begin
                    r.accepted = 1'b0;
                    for (int i = 0; i < run_len; i++) begin
                        if (run_queue[i] == id) begin
                            for (int j = i; j + 1 < run_len; j++)
                                run_queue[j] = run_queue[j + 1];
                            run_len--;
                            r.accepted = 1'b1;
                            break;
                        end
                    end
                end
                default: begin
                    rt_dist = 0;
                    for (int i = 0; i < run_len; i++) begin
                        t = run_queue[i];
                        if (prio[t] < rt_level) break;
                        nxt = last_run[t] + period[t];
                        rt_dist = ((now - nxt) & 32'h8000_0000) == 0 ? 32'd0 : nxt - now;
                    end
                    rt_free = rt_dist > 0;
                    best = 0; found = 0; best_id = 0; waiting = 0;
                    for (int i = 0; i < run_len; i++) begin
                        t = run_queue[i];
                        if (evt[t]) begin
                            sig = mask[t];
                            if (aged[t] > 0) begin
                                age = age_of(t, now);
                                aged[t] = aged_value(prio[t], age);
                                waiting++;
                            end else if (sig) begin
                                age = 1;
                                aged[t] = aged_value(prio[t], 1);
                                waiting++;
                            end else begin
                                age = 0;
                            end
                        end else begin
                            age = age_of(t, now);
                            if (age > 0) begin
                                aged[t] = aged_value(prio[t], age);
                                waiting++;
                            end
                        end
                        if (aged[t] > best &&
                            (rt_free || prio[t] >= rt_level || age > 1)) begin
                            best = aged[t]; best_id = t; found = 1;
                        end
                    end
                    if (found) begin
                        last_run[best_id] = now;
                        aged[best_id] = 0;
                        r.task_valid = 1'b1;
                        r.selected_task = best_id[3:0];
                        ticks_selected++;
                    end
                    r.waiting_count = (waiting > 31) ? 5'd31 : waiting[4:0];
                end
            endcase
            pending.push_back(r);
        endfunction

        function bit check_result(t_sched_result got);
            t_sched_result exp_r;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
                return 0;
            end
            exp_r = pending.pop_front();
            checked++;
            if (got !== exp_r) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: expected acc=%0b val=%0b sel=%0d wait=%0d",
                             exp_r.accepted, exp_r.task_valid, exp_r.selected_task,
                             exp_r.waiting_count);
                    $display("          got      acc=%0b val=%0b sel=%0d wait=%0d",
                             got.accepted, got.task_valid, got.selected_task,
                             got.waiting_count);
                end
                return 0;
            end
            return 1;
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        start = 0;
    logic        busy;
    logic        i_cfg_we = 0;
    logic [7:0]  i_cfg_wdata = 0;
    logic [1:0]  i_mode = MODE_SETUP;
    logic [3:0]  i_task_id = 0;
    logic [7:0]  i_static_priority = 0;
    logic [31:0] i_period_us = 1;
    logic        i_event_driven = 0;
    logic [31:0] i_now_us = 0;
    logic [15:0] i_signal_mask = 0;
    logic        o_done;
    logic        o_accepted;
    logic        o_task_valid;
    logic [3:0]  o_selected_task;
    logic [4:0]  o_waiting_count;

    sched_scoreboard sb;
    int idle_cycles = 0;
    int commands_sent = 0;
    bit quiet_stretch = 0;
    logic [31:0] clock_us = 0;

    always #6 i_clk = ~i_clk;

    aging_priority_task_scheduler_core #(.TASK_SLOTS(SLOTS)) dut (.*);

    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            void'(sb.check_result({o_accepted, o_task_valid, o_selected_task,
                                   o_waiting_count}));
        if (i_rst_n && (o_done || (start && !busy)))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_command(logic [1:0] mode, logic [3:0] id, logic [7:0] sp,
                                logic [31:0] per, logic ev, logic [31:0] now,
                                logic [15:0] mask);
        if (!quiet_stretch)
            while ($urandom_range(99) < 36) @(negedge i_clk);
        i_mode = mode; i_task_id = id; i_static_priority = sp; i_period_us = per;
        i_event_driven = ev; i_now_us = now; i_signal_mask = mask;
        start = 1;
        // busy is stable at the falling edge; low here means the next edge transfers
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        sb.note_command(mode, id, sp, per, ev, now, mask);
        commands_sent++;
        @(negedge i_clk);
        start = 0;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_level(logic [7:0] lvl);
        drain();
        i_cfg_we = 1; i_cfg_wdata = lvl;
        @(negedge i_clk);
        i_cfg_we = 0;
        sb.rt_level = lvl;
    endtask

    task automatic random_tick();
        clock_us = clock_us + $urandom_range(0, 3) * $urandom_range(1, 40);
        if ($urandom_range(19) == 0) clock_us = $urandom;
        send_command(MODE_TICK, 4'($urandom), 8'($urandom), $urandom, 1'($urandom),
                     clock_us, 16'($urandom));
    endtask

    task automatic random_command();
        int pick;
        logic [31:0] per;
        pick = $urandom_range(99);
        per = ($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 20);
        if (pick < 15)
            send_command(MODE_SETUP, 4'($urandom), 8'($urandom), per, 1'($urandom),
                         $urandom, 16'($urandom));
        else if (pick < 32)
            send_command(MODE_ENABLE, 4'($urandom), 8'($urandom), $urandom, 1'($urandom),
                         $urandom, 16'($urandom));
        else if (pick < 42)
            send_command(MODE_DISABLE, 4'($urandom), 8'($urandom), $urandom, 1'($urandom),
                         $urandom, 16'($urandom));
        else
            random_tick();
    endtask

    initial begin
        sb = new();
        repeat (6) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);

        // directed: extremes, overflow, zero period, full queue, missing task
        send_command(MODE_TICK, 0, 0, 1, 0, 32'h0, 16'h0);
        send_command(MODE_DISABLE, 4'd3, 0, 1, 0, 0, 0);
        send_command(MODE_SETUP, 4'd0, 8'hFF, 32'd1, 1'b0, 0, 0);
        send_command(MODE_SETUP, 4'd15, 8'd0, 32'd0, 1'b1, 0, 0);
        send_command(MODE_SETUP, 4'd5, 8'd7, 32'hFFFF_FFFF, 1'b0, 0, 0);
        for (int i = 0; i < SLOTS; i++)
            send_command(MODE_ENABLE, i[3:0], 0, 1, 0, 0, 0);
        send_command(MODE_ENABLE, 4'd4, 0, 1, 0, 0, 0);
        send_command(MODE_TICK, 0, 0, 1, 0, 32'hFFFF_FFFF, 16'hFFFF);
        send_command(MODE_TICK, 0, 0, 1, 0, 32'h8000_0000, 16'hAAAA);
        send_command(MODE_DISABLE, 4'd15, 0, 1, 0, 0, 0);
        send_command(MODE_TICK, 0, 0, 1, 0, 32'h1234, 16'h5555);

        // pause until everything has come back, then move through levels
        drain();
        write_level(8'd0);
        for (int i = 0; i < 200; i++) random_command();
        write_level(8'd255);
        quiet_stretch = 1;
        for (int i = 0; i < 150; i++) random_command();
        quiet_stretch = 0;
        write_level(8'($urandom_range(1, 254)));
        for (int i = 0; i < 300; i++) random_command();
        write_level(8'd6);
        for (int i = 0; i < 330; i++) random_command();

        drain();
        repeat (700) @(negedge i_clk);
        $display("covered %0d commands, %0d results checked, %0d ticks picked a task",
                 commands_sent, sb.checked, sb.ticks_selected);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

>>> sim.f
hw/rtl/apts_pkg.sv
hw/rtl/apts_divider.sv
hw/rtl/aging_priority_task_scheduler_core.sv
dv/aging_priority_task_scheduler_core_tb.sv
